// ===== rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the bitmap page allocator.
// No dependencies; used by every other file under rtl/.
package bpa_pkg;

    localparam int WORDS      = 1024;
    localparam int WORD_AW    = 10;
    localparam int WORD_BITS  = 64;
    localparam int BIT_AW     = 6;
    localparam int PAGE_W     = 16;
    localparam int CFG_W      = 17;
    localparam int ADDR_W     = 48;
    localparam int PA_W       = 28;
    localparam int PAGE_SHIFT = 12;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;

    localparam logic [CFG_W-1:0]     CAPACITY          = 17'd65536;
    localparam logic [CFG_W-1:0]     TOTAL_PAGES_RESET = 17'd65536;
    localparam logic [WORD_BITS-1:0] ALL_USED          = {WORD_BITS{1'b1}};
    localparam logic [WORD_AW-1:0]   LAST_WORD         = WORD_AW'(WORDS - 1);

    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RESERVE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ALIGN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREE  = 3'd4;

    typedef struct packed {
        logic                 rd_en;
        logic [WORD_AW-1:0]   rd_addr;
        logic                 wr_en;
        logic [WORD_AW-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                valid;
        logic [PA_W-1:0]     page_address;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Index of the lowest clear bit; zero when the word is full.
    function automatic logic [BIT_AW-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
        logic [BIT_AW-1:0] b;
        b = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                b = BIT_AW'(i);
            end
        end
        return b;
    endfunction

endpackage

// ===== rtl/bpa_bitmap_mem.sv =====
`timescale 1ns / 1ps
// Page bitmap storage: one write port, one read port with registered data.
// Depends on bpa_pkg.
module bpa_bitmap_mem (
    input  logic                          clk,
    input  bpa_pkg::mem_req_t             req,
    output logic [bpa_pkg::WORD_BITS-1:0] rd_data
);

    logic [bpa_pkg::WORD_BITS-1:0] mem [bpa_pkg::WORDS];
    logic [bpa_pkg::WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bpa_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the allocator: clearing pass, word scan, read-modify-write
// of the bitmap and the search hint. Depends on bpa_pkg.
module bpa_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bpa_pkg::FUNC_W-1:0]    func,
    input  logic [bpa_pkg::ADDR_W-1:0]    address,
    input  logic [bpa_pkg::CFG_W-1:0]     page_limit,
    input  logic                          res_take,
    output bpa_pkg::result_t              res,
    output bpa_pkg::mem_req_t             mem_req,
    input  logic [bpa_pkg::WORD_BITS-1:0] rd_data
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [bpa_pkg::WORD_AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [bpa_pkg::WORD_AW-1:0]     hint_reg, hint_next;
    logic [bpa_pkg::WORD_AW-1:0]     scan_addr_reg, scan_addr_next;
    logic [bpa_pkg::FUNC_W-1:0]      func_reg, func_next;
    logic [bpa_pkg::PAGE_W-1:0]      page_reg, page_next;
    logic [bpa_pkg::STATUS_W-1:0]    err_reg, err_next;

    logic                            accept;
    logic [bpa_pkg::STATUS_W-1:0]    in_err;
    logic                            in_hi_zero;
    logic [bpa_pkg::BIT_AW-1:0]      found_bit;
    logic [bpa_pkg::PAGE_W-1:0]      found_page;
    logic                            found_ok;
    logic [bpa_pkg::WORD_BITS-1:0]   found_mask;
    logic [bpa_pkg::WORD_BITS-1:0]   page_mask;
    logic [bpa_pkg::WORD_AW-1:0]     page_word;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign in_hi_zero = (address[bpa_pkg::ADDR_W-1:bpa_pkg::PA_W] == '0);

    // Checks that need only the request and the page limit, not the bitmap
    always_comb
    begin
        in_err = bpa_pkg::ST_OK;
        case (func)
            bpa_pkg::FN_FREE:
            begin
                if (address[bpa_pkg::PAGE_SHIFT-1:0] != '0)
                begin
                    in_err = bpa_pkg::ST_ALIGN;
                end
                else if (!in_hi_zero ||
                         {1'b0, address[bpa_pkg::PA_W-1:bpa_pkg::PAGE_SHIFT]} >= page_limit)
                begin
                    in_err = bpa_pkg::ST_RANGE;
                end
            end
            bpa_pkg::FN_RESERVE, bpa_pkg::FN_RELEASE:
            begin
                if (!in_hi_zero)
                begin
                    in_err = bpa_pkg::ST_RANGE;
                end
            end
            default:
            begin
                in_err = bpa_pkg::ST_OK;
            end
        endcase
    end

    assign found_bit  = bpa_pkg::lowest_clear(rd_data);
    assign found_page = {scan_addr_reg, found_bit};
    assign found_ok   = ({1'b0, found_page} < page_limit);
    assign found_mask = bpa_pkg::WORD_BITS'(1) << found_bit;
    assign page_mask  = bpa_pkg::WORD_BITS'(1) << page_reg[bpa_pkg::BIT_AW-1:0];
    assign page_word  = page_reg[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_AW];

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        hint_next      = hint_reg;
        scan_addr_next = scan_addr_reg;
        func_next      = func_reg;
        page_next      = page_reg;
        err_next       = err_reg;
        mem_req        = '0;
        res            = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_addr_reg;
                mem_req.wr_data = bpa_pkg::ALL_USED;
                clr_addr_next   = clr_addr_reg + 1'b1;
                if (clr_addr_reg == bpa_pkg::LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    func_next      = func;
                    page_next      = address[bpa_pkg::PA_W-1:bpa_pkg::PAGE_SHIFT];
                    err_next       = in_err;
                    scan_addr_next = hint_reg;
                    if (func == bpa_pkg::FN_ALLOC)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = hint_reg;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        mem_req.rd_en   = (in_err == bpa_pkg::ST_OK);
                        mem_req.rd_addr = address[bpa_pkg::PA_W-1:bpa_pkg::PAGE_SHIFT+bpa_pkg::BIT_AW];
                        state_next      = S_CHECK;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_data != bpa_pkg::ALL_USED)
                begin
                    res.valid = 1'b1;
                    if (found_ok)
                    begin
                        res.status       = bpa_pkg::ST_OK;
                        res.page_address = {found_page, {bpa_pkg::PAGE_SHIFT{1'b0}}};
                    end
                    else
                    begin
                        res.status = bpa_pkg::ST_NONE;
                    end
                    if (res_take)
                    begin
                        state_next = S_IDLE;
                        if (found_ok)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = scan_addr_reg;
                            mem_req.wr_data = rd_data | found_mask;
                            hint_next       = scan_addr_reg;
                        end
                    end
                end
                else if (scan_addr_reg == bpa_pkg::LAST_WORD)
                begin
                    res.valid  = 1'b1;
                    res.status = bpa_pkg::ST_NONE;
                    if (res_take)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // advance to the next word, one read per cycle
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_addr_reg + 1'b1;
                    scan_addr_next  = scan_addr_reg + 1'b1;
                end
            end

            S_CHECK:
            begin
                res.valid  = 1'b1;
                res.status = err_reg;
                if (err_reg == bpa_pkg::ST_OK && func_reg == bpa_pkg::FN_FREE &&
                    (rd_data & page_mask) == '0)
                begin
                    res.status = bpa_pkg::ST_FREE;
                end
                if (res_take)
                begin
                    state_next      = S_IDLE;
                    mem_req.wr_addr = page_word;
                    if (err_reg == bpa_pkg::ST_OK)
                    begin
                        case (func_reg)
                            bpa_pkg::FN_FREE:
                            begin
                                if ((rd_data & page_mask) != '0)
                                begin
                                    mem_req.wr_en   = 1'b1;
                                    mem_req.wr_data = rd_data & ~page_mask;
                                    if (page_word < hint_reg)
                                    begin
                                        hint_next = page_word;
                                    end
                                end
                            end
                            bpa_pkg::FN_RESERVE:
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_data = rd_data | page_mask;
                            end
                            bpa_pkg::FN_RELEASE:
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_data = rd_data & ~page_mask;
                            end
                            default:
                            begin
                                mem_req.wr_en = 1'b0;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            hint_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            hint_reg     <= hint_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        func_reg      <= func_next;
        page_reg      <= page_next;
        err_reg       <= err_next;
    end

    // A read never meets a write to the same word in one cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
        else $error("bitmap read and write collide");

    a_accept_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCAN || state_reg == S_CHECK))
        else $error("accepted request did not start work");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!res.valid && !mem_req.rd_en))
        else $error("activity during clearing pass");

    a_scan_above_hint: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_addr_reg >= hint_reg))
        else $error("scan below search hint");

    a_alloc_ok_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && res.valid && res_take && res.status == bpa_pkg::ST_OK)
        |-> (mem_req.wr_en && mem_req.wr_addr == scan_addr_reg))
        else $error("allocation without bitmap update");

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the bitmap page allocator: configuration register, result
// register, bitmap memory and its sequencer. Depends on bpa_pkg, bpa_bitmap_mem, bpa_ctrl.
//
//   channel   signals                             direction  accepted when
//   request   in_valid, in_stall, func, address    in         in_valid && !in_stall
//   result    out_valid, out_stall, page_address,  out        out_valid && !out_stall
//             status
//   config    cfg_valid, cfg_ready, cfg_data       in         cfg_valid && cfg_ready
//
// After reset a clearing pass over every bitmap word marks every page used; no
// request is taken then, configuration writes are.
// Free, reserve and release accept with the word read, then check and write
// back. Alloc reads the words from the hint up to the first non-full one, one
// word per cycle through the single read port of the bitmap memory.
// One request is in flight at a time; a finished result waits in the result
// register while the next request is accepted, and a stalled result holds the
// sequencer at the write-back step.
module bitmap_page_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bpa_pkg::FUNC_W-1:0]    func,
    input  logic [bpa_pkg::ADDR_W-1:0]    address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bpa_pkg::PA_W-1:0]      page_address,
    output logic [bpa_pkg::STATUS_W-1:0]  status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpa_pkg::CFG_W-1:0]     cfg_data
);

    logic [bpa_pkg::CFG_W-1:0]     total_pages_reg;
    logic [bpa_pkg::CFG_W-1:0]     page_limit;
    logic                          out_valid_reg, out_valid_next;
    logic [bpa_pkg::PA_W-1:0]      page_address_reg;
    logic [bpa_pkg::STATUS_W-1:0]  status_reg;
    logic                          slot_free;
    logic                          out_load;
    bpa_pkg::result_t              res;
    bpa_pkg::mem_req_t             mem_req;
    logic [bpa_pkg::WORD_BITS-1:0] rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg <= bpa_pkg::TOTAL_PAGES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            total_pages_reg <= cfg_data;
        end
    end

    assign page_limit = (total_pages_reg > bpa_pkg::CAPACITY) ? bpa_pkg::CAPACITY
                                                              : total_pages_reg;

    // Result register frees up when empty or when its result is taken
    assign slot_free      = !out_valid_reg || !out_stall;
    assign out_load       = res.valid && slot_free;
    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            page_address_reg <= res.page_address;
            status_reg       <= res.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign page_address = page_address_reg;
    assign status       = status_reg;

    bpa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .address    (address),
        .page_limit (page_limit),
        .res_take   (slot_free),
        .res        (res),
        .mem_req    (mem_req),
        .rd_data    (rd_data)
    );

    bpa_bitmap_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

// ===== dv/bpa_checker.sv =====
`timescale 1ns / 1ps
// Checker for the bitmap page allocator: watches the request, result and
// configuration channels, predicts every result and compares. Depends on bpa_pkg.
module bpa_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [bpa_pkg::FUNC_W-1:0]    func,
    input  logic [bpa_pkg::ADDR_W-1:0]    address,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [bpa_pkg::PA_W-1:0]      page_address,
    input  logic [bpa_pkg::STATUS_W-1:0]  status,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bpa_pkg::CFG_W-1:0]     cfg_data,
    output int                            fail_total,
    output int                            results_due
);

    typedef struct {
        logic [bpa_pkg::PA_W-1:0]     page_address;
        logic [bpa_pkg::STATUS_W-1:0] status;
    } grant_t;

    logic [bpa_pkg::WORD_BITS-1:0] used_map [bpa_pkg::WORDS];
    logic [bpa_pkg::WORD_AW-1:0]   hint_word;
    logic [bpa_pkg::CFG_W-1:0]     page_count;
    grant_t                        grants_due [$];
    int                            fail_count;

    function automatic int page_limit();
        return (page_count < bpa_pkg::CAPACITY) ? int'(page_count)
                                                : int'(bpa_pkg::CAPACITY);
    endfunction

    task automatic report(input string msg);
        if (fail_count < 50)
        begin
            $display("%0t ns allocator mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    // Scan up from the hint; stop at the first word with a clear bit.
    task automatic grant_page(output grant_t g);
        logic [bpa_pkg::WORD_BITS-1:0] w;
        int                            b;
        int                            page;
        bit                            found;
        g.page_address = '0;
        g.status       = bpa_pkg::ST_NONE;
        found          = 1'b0;
        for (int i = int'(hint_word); i < bpa_pkg::WORDS && !found; i++)
        begin
            if (used_map[i] != bpa_pkg::ALL_USED)
            begin
                found = 1'b1;
                w     = used_map[i];
                b     = 0;
                while (w[b])
                begin
                    b++;
                end
                page = i * bpa_pkg::WORD_BITS + b;
                if (page < page_limit())
                begin
                    used_map[i][b] = 1'b1;
                    hint_word      = bpa_pkg::WORD_AW'(i);
                    g.page_address = bpa_pkg::PA_W'(page * 4096);
                    g.status       = bpa_pkg::ST_OK;
                end
            end
        end
    endtask

    task automatic return_page(input logic [bpa_pkg::ADDR_W-1:0] a, output grant_t g);
        logic [bpa_pkg::ADDR_W-bpa_pkg::PAGE_SHIFT-1:0] page;
        logic [bpa_pkg::WORD_AW-1:0]                    word;
        page           = a[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
        word           = page[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_AW];
        g.page_address = '0;
        if (a[bpa_pkg::PAGE_SHIFT-1:0] != '0)
        begin
            g.status = bpa_pkg::ST_ALIGN;
        end
        else if (page >= page_limit())
        begin
            g.status = bpa_pkg::ST_RANGE;
        end
        else if (!used_map[word][page[bpa_pkg::BIT_AW-1:0]])
        begin
            g.status = bpa_pkg::ST_FREE;
        end
        else
        begin
            used_map[word][page[bpa_pkg::BIT_AW-1:0]] = 1'b0;
            if (word < hint_word)
            begin
                hint_word = word;
            end
            g.status = bpa_pkg::ST_OK;
        end
    endtask

    // Reserve and release: low address bits ignored, only capacity checked.
    task automatic mark_page(input logic [bpa_pkg::ADDR_W-1:0] a, input logic used,
                             output grant_t g);
        logic [bpa_pkg::ADDR_W-bpa_pkg::PAGE_SHIFT-1:0] page;
        page           = a[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
        g.page_address = '0;
        if (page >= bpa_pkg::CAPACITY)
        begin
            g.status = bpa_pkg::ST_RANGE;
        end
        else
        begin
            used_map[page[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_AW]][page[bpa_pkg::BIT_AW-1:0]] = used;
            g.status = bpa_pkg::ST_OK;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t g;
        grant_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < bpa_pkg::WORDS; i++)
            begin
                used_map[i] = bpa_pkg::ALL_USED;
            end
            hint_word  = '0;
            page_count = bpa_pkg::TOTAL_PAGES_RESET;
            grants_due.delete();
            fail_count = 0;
            fail_total  <= 0;
            results_due <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                page_count = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (grants_due.size() == 0)
                begin
                    report($sformatf("unexpected result page_address=%h status=%0d",
                                     page_address, status));
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (page_address !== want.page_address)
                    begin
                        report($sformatf("page_address %h, predicted %h",
                                         page_address, want.page_address));
                    end
                    if (status !== want.status)
                    begin
                        report($sformatf("status %0d, predicted %0d",
                                         status, want.status));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                case (func)
                    bpa_pkg::FN_ALLOC:   grant_page(g);
                    bpa_pkg::FN_FREE:    return_page(address, g);
                    bpa_pkg::FN_RESERVE: mark_page(address, 1'b1, g);
                    default:             mark_page(address, 1'b0, g);
                endcase
                grants_due.push_back(g);
            end
            fail_total  <= fail_count;
            results_due <= grants_due.size();
        end
    end

endmodule

// ===== dv/tb_bitmap_page_allocator.sv =====
`timescale 1ns / 1ps
// Testbench top for the bitmap page allocator: clock, reset, request and
// configuration stimulus, verdict. Depends on bpa_pkg, bitmap_page_allocator and bpa_checker.
module tb_bitmap_page_allocator;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [bpa_pkg::FUNC_W-1:0]   func;
    logic [bpa_pkg::ADDR_W-1:0]   address;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [bpa_pkg::PA_W-1:0]     page_address;
    logic [bpa_pkg::STATUS_W-1:0] status;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [bpa_pkg::CFG_W-1:0]    cfg_data;
    int                           fail_total;
    int                           results_due;
    int                           sender_idle;
    int                           receiver_idle;

    always #5 clk = ~clk;

    bitmap_page_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .address      (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .page_address (page_address),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    bpa_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .address      (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .page_address (page_address),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_total   (fail_total),
        .results_due  (results_due)
    );

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < receiver_idle);
    end

    // Hold the request until accepted; idle first at the sender's rate.
    task automatic issue(input logic [bpa_pkg::FUNC_W-1:0] f,
                         input logic [bpa_pkg::ADDR_W-1:0] a);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        address  <= a;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_total_pages(input logic [bpa_pkg::CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly pages in the first dozen words, some anywhere, a few wild addresses.
    function automatic logic [bpa_pkg::ADDR_W-1:0] pick_address();
        logic [63:0] wide;
        int          r;
        r    = $urandom_range(0, 99);
        wide = {$urandom(), $urandom()};
        if (r < 80)
        begin
            return bpa_pkg::ADDR_W'($urandom_range(0, 767)) << bpa_pkg::PAGE_SHIFT;
        end
        else if (r < 95)
        begin
            return bpa_pkg::ADDR_W'($urandom_range(0, 65535)) << bpa_pkg::PAGE_SHIFT;
        end
        return wide[bpa_pkg::ADDR_W-1:0];
    endfunction

    task automatic random_request();
        logic [bpa_pkg::ADDR_W-1:0] a;
        logic [bpa_pkg::FUNC_W-1:0] f;
        int                         pick;
        pick = $urandom_range(0, 99);
        a    = pick_address();
        if (pick < 35)
        begin
            f = bpa_pkg::FN_ALLOC;
        end
        else if (pick < 65)
        begin
            f = bpa_pkg::FN_FREE;
        end
        else if (pick < 85)
        begin
            f = bpa_pkg::FN_RELEASE;
        end
        else
        begin
            f = bpa_pkg::FN_RESERVE;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            a[bpa_pkg::PAGE_SHIFT-1:0] = bpa_pkg::PAGE_SHIFT'($urandom_range(1, 4095));
        end
        issue(f, a);
    endtask

    initial
    begin : stimulus
        logic [bpa_pkg::CFG_W-1:0] phase_pages [3];
        int                        wait_cycles;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = bpa_pkg::FN_ALLOC;
        address       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        sender_idle   = 0;
        receiver_idle = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        set_total_pages(bpa_pkg::CAPACITY);
        // every page starts used: full scan fails
        issue(bpa_pkg::FN_ALLOC, '0);
        issue(bpa_pkg::FN_RELEASE, 48'h0);
        issue(bpa_pkg::FN_RELEASE, 48'h1FFF);
        issue(bpa_pkg::FN_RELEASE, 48'hFFF_F000);
        issue(bpa_pkg::FN_RELEASE, 48'hFFFF_FFFF_FFFF);
        issue(bpa_pkg::FN_RESERVE, 48'h1000_0000);
        issue(bpa_pkg::FN_ALLOC, 48'hFFFF_FFFF_FFFF);
        issue(bpa_pkg::FN_ALLOC, '0);
        // word 0 now full: scan reaches the last page
        issue(bpa_pkg::FN_ALLOC, '0);
        issue(bpa_pkg::FN_FREE, 48'h800);
        issue(bpa_pkg::FN_FREE, 48'h1000_0000);
        issue(bpa_pkg::FN_FREE, 48'h0);
        issue(bpa_pkg::FN_FREE, 48'h0);
        issue(bpa_pkg::FN_RESERVE, 48'h0);
        issue(bpa_pkg::FN_FREE, 48'hFFF_F000);

        drain();
        set_total_pages(17'd1);
        issue(bpa_pkg::FN_FREE, 48'h1000);
        issue(bpa_pkg::FN_RELEASE, 48'h5000);
        issue(bpa_pkg::FN_RELEASE, 48'h0);
        issue(bpa_pkg::FN_ALLOC, '0);
        // first clear bit lies past the limit
        issue(bpa_pkg::FN_ALLOC, '0);
        issue(bpa_pkg::FN_RESERVE, 48'h5000);

        phase_pages[0] = bpa_pkg::CAPACITY;
        phase_pages[1] = bpa_pkg::CFG_W'($urandom_range(64, 768));
        phase_pages[2] = bpa_pkg::CFG_W'($urandom_range(1, 65536));
        for (int p = 0; p < 3; p++)
        begin
            drain();
            set_total_pages(phase_pages[p]);
            sender_idle   = (p == 0) ? 22 : (p == 1) ? 76 : 0;
            receiver_idle = (p == 0) ? 76 : (p == 1) ? 22 : 0;
            for (int n = 0; n < 210; n++)
            begin
                if (n == 105)
                begin
                    drain();
                end
                random_request();
            end
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        do
        begin
            @(posedge clk);
            wait_cycles++;
        end
        while (results_due != 0 && wait_cycles < 20000);
        repeat (8) @(posedge clk);
        if (fail_total == 0 && results_due == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin : watchdog
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
